[design/assert_macros.svh]
// assertion macros for the complex accumulator unit
// no dependencies; assumes a clock named clk and reset named arst_n at the use site
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define CAL_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CAL_ASSERT(lbl, prop)
`define CAL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/cal_pkg.sv]
// shared codes and types for the complex accumulator unit
// no dependencies
`timescale 1ns / 1ps
package cal_pkg;
	localparam logic [3:0] OP_ADD     = 4'd0;
	localparam logic [3:0] OP_SUB     = 4'd1;
	localparam logic [3:0] OP_MUL     = 4'd2;
	localparam logic [3:0] OP_DIV     = 4'd3;
	localparam logic [3:0] OP_ADD_A   = 4'd4;
	localparam logic [3:0] OP_SUB_A   = 4'd5;
	localparam logic [3:0] OP_MUL_A   = 4'd6;
	localparam logic [3:0] OP_DIV_A   = 4'd7;
	localparam logic [3:0] OP_PREINC  = 4'd8;
	localparam logic [3:0] OP_POSTINC = 4'd9;
	localparam logic [3:0] OP_PREDEC  = 4'd10;
	localparam logic [3:0] OP_POSTDEC = 4'd11;
	localparam logic [3:0] OP_LOAD    = 4'd12;

	typedef struct packed {
		logic busy;
		logic done;
		logic sat;
	} div_stat_t;
endpackage

[design/cal_div.sv]
// iterative restoring divider, one quotient bit per cycle, rounded and clipped
// depends on cal_pkg
`timescale 1ns / 1ps
module cal_div import cal_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [2*WORD_BITS:0]  num,
	input  logic        [2*WORD_BITS-1:0] den,
	output logic signed [WORD_BITS-1:0]  quot,
	output div_stat_t                    stat
);
	localparam int W  = WORD_BITS;
	localparam int SW = 2 * W + 1;
	localparam int DW = 3 * W + FRAC_BITS + 2;
	localparam int CB = $clog2(W + 2);
	localparam logic [W:0] HI_M = {2'b00, {(W - 1){1'b1}}};
	localparam logic [W:0] LO_M = {2'b01, {(W - 1){1'b0}}};

	logic [DW-1:0] n_q, d_q;
	logic [W:0]    q_q;
	logic          neg_q, busy_q, done_q;
	logic [CB-1:0] cnt_q;
	logic [SW-1:0] mag;
	logic          ge;

	assign mag = num[SW-1] ? SW'(-num) : SW'(num);
	assign ge  = n_q >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(W + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= (DW'(mag) << FRAC_BITS) + DW'(den >> 1);
			d_q   <= DW'(den) << W;
			neg_q <= num[SW-1];
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) n_q <= n_q - d_q;
			d_q <= d_q >> 1;
			q_q <= {q_q[W-1:0], ge};
		end
	end

	// clip magnitude to the signed range, then apply the sign
	always_comb begin
		stat.busy = busy_q;
		stat.done = done_q;
		if (neg_q) begin
			stat.sat = q_q > LO_M;
			quot     = stat.sat ? LO_M[W-1:0] : -q_q[W-1:0];
		end else begin
			stat.sat = q_q > HI_M;
			quot     = stat.sat ? HI_M[W-1:0] : q_q[W-1:0];
		end
	end
endmodule

[design/complex_accumulator_alu.sv]
// complex accumulator unit, top level: sequencer, shared multiplier, accumulator
// depends on cal_pkg, cal_div and assert_macros.svh
`timescale 1ns / 1ps
// One transaction at a time. Add, subtract, increment, decrement and load pass
// through the execute state to the output register; multiply sends four products
// through the one registered multiplier, then rounds; divide sends six products
// through the shared multiplier, then makes two passes of the bit-serial
// divider; a zero divisor ends without starting the divider.
// in_stall is high while a transaction is in work;
// a finished result may still wait in the output register meanwhile.
module complex_accumulator_alu import cal_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  operation,
	input  logic signed [WORD_BITS-1:0] operand_real,
	input  logic signed [WORD_BITS-1:0] operand_imag,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] result_real,
	output logic signed [WORD_BITS-1:0] result_imag,
	output logic                        divide_by_zero,
	output logic                        saturated
);
	`include "assert_macros.svh"

	localparam int W  = WORD_BITS;
	localparam int SW = 2 * W + 1;
	localparam logic signed [SW-1:0] HI_S = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [SW-1:0] LO_S = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};
	localparam logic [SW-1:0] ONE_S  = SW'(1) << FRAC_BITS;
	localparam logic [SW-1:0] HALF_S = SW'(1) << (FRAC_BITS - 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_PROD = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_DIVZ = 3'd4;
	localparam logic [2:0] ST_DIVR = 3'd5;
	localparam logic [2:0] ST_DIVI = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	// clip a wide signed value: {sat, value}
	function automatic logic [W:0] clip(input logic signed [SW-1:0] x);
		logic [W:0] r;
		if (x > HI_S)      r = {1'b1, HI_S[W-1:0]};
		else if (x < LO_S) r = {1'b1, LO_S[W-1:0]};
		else               r = {1'b0, x[W-1:0]};
		return r;
	endfunction

	// scale a product sum down by the fraction, nearest, ties away from zero
	function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] x);
		logic [SW-1:0] m;
		m = x[SW-1] ? SW'(-x) : SW'(x);
		m = (m + HALF_S) >> FRAC_BITS;
		return x[SW-1] ? -$signed(m) : $signed(m);
	endfunction

	logic [2:0]          state_q;
	logic [3:0]          op_q;
	logic signed [W-1:0] ar_q, ai_q, br_q, bi_q;
	logic signed [W-1:0] res_r_q, res_i_q;
	logic                dz_q, sat_q;
	logic [2:0]          k_q;
	logic signed [2*W-1:0] prod_s1;
	logic signed [SW-1:0]  pr_q, pi_q;
	logic [2*W-1:0]        den_q;
	logic                  out_valid_q;
	logic signed [W-1:0]   res_r_o, res_i_o;
	logic                  dz_o, sat_o;

	// shared multiplier operand select
	logic signed [W-1:0] mul_a, mul_b;
	always_comb begin
		case (k_q)
			3'd0:    begin mul_a = ar_q; mul_b = br_q; end
			3'd1:    begin mul_a = ai_q; mul_b = bi_q; end
			3'd2:    begin mul_a = ar_q; mul_b = bi_q; end
			3'd3:    begin mul_a = ai_q; mul_b = br_q; end
			3'd4:    begin mul_a = br_q; mul_b = br_q; end
			default: begin mul_a = bi_q; mul_b = bi_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// combinational arithmetic for the simple forms
	logic signed [SW-1:0] ar_x, ai_x, br_x, bi_x;
	logic [W:0] add_r, add_i, sub_r, sub_i, inc_r, inc_i, dec_r, dec_i, mr, mi;
	assign ar_x  = SW'(ar_q);
	assign ai_x  = SW'(ai_q);
	assign br_x  = SW'(br_q);
	assign bi_x  = SW'(bi_q);
	assign add_r = clip(ar_x + br_x);
	assign add_i = clip(ai_x + bi_x);
	assign sub_r = clip(ar_x - br_x);
	assign sub_i = clip(ai_x - bi_x);
	assign inc_r = clip(ar_x + $signed(ONE_S));
	assign inc_i = clip(ai_x + $signed(ONE_S));
	assign dec_r = clip(ar_x - $signed(ONE_S));
	assign dec_i = clip(ai_x - $signed(ONE_S));
	assign mr    = clip(rnd(pr_q));
	assign mi    = clip(rnd(pi_q));

	// divider, shared by the real and imaginary quotients
	logic                 div_start;
	logic signed [SW-1:0] div_num;
	logic signed [W-1:0]  div_quot;
	div_stat_t            div_stat;

	assign div_start = (state_q == ST_DIVZ && den_q != '0) ||
	                   (state_q == ST_DIVR && div_stat.done);
	assign div_num   = (state_q == ST_DIVZ) ? pr_q : pi_q;

	cal_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (den_q),
		.quot  (div_quot),
		.stat  (div_stat)
	);

	logic is_div, out_free;
	assign is_div   = op_q[0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			ar_q        <= '0;
			ai_q        <= '0;
		end else begin
			// a new result replaces a taken one, otherwise a taken one is dropped
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					case (op_q) inside
						OP_ADD, OP_ADD_A: begin
							state_q <= ST_DONE;
							if (op_q[2]) begin
								ar_q <= add_r[W-1:0];
								ai_q <= add_i[W-1:0];
							end
						end
						OP_SUB, OP_SUB_A: begin
							state_q <= ST_DONE;
							if (op_q[2]) begin
								ar_q <= sub_r[W-1:0];
								ai_q <= sub_i[W-1:0];
							end
						end
						OP_MUL, OP_MUL_A, OP_DIV, OP_DIV_A: begin
							state_q <= ST_PROD;
							k_q     <= '0;
						end
						OP_PREINC, OP_POSTINC: begin
							state_q <= ST_DONE;
							ar_q    <= inc_r[W-1:0];
							ai_q    <= inc_i[W-1:0];
						end
						OP_PREDEC, OP_POSTDEC: begin
							state_q <= ST_DONE;
							ar_q    <= dec_r[W-1:0];
							ai_q    <= dec_i[W-1:0];
						end
						OP_LOAD: begin
							state_q <= ST_DONE;
							ar_q    <= br_q;
							ai_q    <= bi_q;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_PROD: begin
					k_q <= k_q + 1'b1;
					if (!is_div && k_q == 3'd4) state_q <= ST_RND;
					if (is_div && k_q == 3'd6)  state_q <= ST_DIVZ;
				end
				ST_RND: begin
					state_q <= ST_DONE;
					if (op_q[2]) begin
						ar_q <= mr[W-1:0];
						ai_q <= mi[W-1:0];
					end
				end
				ST_DIVZ: begin
					if (den_q == '0) begin
						state_q <= ST_DONE;
						if (op_q[2]) begin
							ar_q <= ar_q[W-1] ? LO_S[W-1:0] : HI_S[W-1:0];
							ai_q <= ai_q[W-1] ? LO_S[W-1:0] : HI_S[W-1:0];
						end
					end else begin
						state_q <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (div_stat.done) state_q <= ST_DIVI;
				end
				ST_DIVI: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
						if (op_q[2]) begin
							ar_q <= res_r_q;
							ai_q <= div_quot;
						end
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand capture, product accumulation and the pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q <= operation;
			br_q <= operand_real;
			bi_q <= operand_imag;
		end
		if (state_q == ST_PROD) begin
			case (k_q)
				3'd1:    pr_q  <= SW'(prod_s1);
				3'd2:    pr_q  <= is_div ? pr_q + SW'(prod_s1) : pr_q - SW'(prod_s1);
				3'd3:    pi_q  <= is_div ? -SW'(prod_s1) : SW'(prod_s1);
				3'd4:    pi_q  <= pi_q + SW'(prod_s1);
				3'd5:    den_q <= prod_s1[2*W-1:0];
				3'd6:    den_q <= den_q + prod_s1[2*W-1:0];
				default: ;
			endcase
		end
		unique case (state_q)
			ST_EXEC: begin
				dz_q <= 1'b0;
				case (op_q) inside
					OP_ADD, OP_ADD_A: begin
						res_r_q <= add_r[W-1:0];
						res_i_q <= add_i[W-1:0];
						sat_q   <= add_r[W] | add_i[W];
					end
					OP_SUB, OP_SUB_A: begin
						res_r_q <= sub_r[W-1:0];
						res_i_q <= sub_i[W-1:0];
						sat_q   <= sub_r[W] | sub_i[W];
					end
					OP_PREINC, OP_POSTINC: begin
						res_r_q <= (op_q == OP_PREINC) ? inc_r[W-1:0] : ar_q;
						res_i_q <= (op_q == OP_PREINC) ? inc_i[W-1:0] : ai_q;
						sat_q   <= inc_r[W] | inc_i[W];
					end
					OP_PREDEC, OP_POSTDEC: begin
						res_r_q <= (op_q == OP_PREDEC) ? dec_r[W-1:0] : ar_q;
						res_i_q <= (op_q == OP_PREDEC) ? dec_i[W-1:0] : ai_q;
						sat_q   <= dec_r[W] | dec_i[W];
					end
					OP_LOAD: begin
						res_r_q <= br_q;
						res_i_q <= bi_q;
						sat_q   <= 1'b0;
					end
					default: begin
						res_r_q <= ar_q;
						res_i_q <= ai_q;
						sat_q   <= 1'b0;
					end
				endcase
			end
			ST_RND: begin
				res_r_q <= mr[W-1:0];
				res_i_q <= mi[W-1:0];
				sat_q   <= mr[W] | mi[W];
			end
			ST_DIVZ: begin
				if (den_q == '0) begin
					res_r_q <= ar_q[W-1] ? LO_S[W-1:0] : HI_S[W-1:0];
					res_i_q <= ai_q[W-1] ? LO_S[W-1:0] : HI_S[W-1:0];
					dz_q    <= 1'b1;
					sat_q   <= 1'b1;
				end
			end
			ST_DIVR: begin
				if (div_stat.done) begin
					res_r_q <= div_quot;
					sat_q   <= div_stat.sat;
				end
			end
			ST_DIVI: begin
				if (div_stat.done) begin
					res_i_q <= div_quot;
					sat_q   <= sat_q | div_stat.sat;
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			res_r_o <= res_r_q;
			res_i_o <= res_i_q;
			dz_o    <= dz_q;
			sat_o   <= sat_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_real    = res_r_o;
	assign result_imag    = res_i_o;
	assign divide_by_zero = dz_o;
	assign saturated      = sat_o;

	// a zero divisor always reports clipping as well
	`CAL_ASSERT(a_dz_sat, out_valid && divide_by_zero |-> saturated)
	// divider finishes only while the sequencer waits on it
	`CAL_ASSERT(a_div_done, div_stat.done |-> (state_q == ST_DIVR || state_q == ST_DIVI))
	// an accepted transaction starts decoding in the next cycle
	`CAL_ASSERT(a_accept, in_valid && !in_stall |=> state_q == ST_EXEC)
	// divider is never restarted while busy
	`CAL_ASSERT_ALWAYS(a_div_start, div_start |-> !div_stat.busy || !arst_n)
endmodule
